FILE: design/u8wd_pkg.sv
// types, constants and helper functions shared by the utf-8 decoder modules
package u8wd_pkg;

  localparam logic [20:0] REPL_CP = 21'h00fffd;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       text_end;
  } in_item_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        wrap_found;
    logic        text_done;
    logic        run_last;
  } out_item_t;

  // one accepted byte, described as: pre_n replacements, optional code point, replacements
  typedef struct packed {
    logic [2:0]  tot_n;
    logic [2:0]  pre_n;
    logic        has_x;
    logic [20:0] x_cp;
    logic        wrap_pre;
    logic        wrap_post;
    logic        text_end;
  } desc_t;

  typedef struct packed {
    logic idle;
    logic wrap;
  } front_stat_t;

  // continuation bytes a lead byte calls for
  function automatic logic [1:0] need_of(input logic [7:0] lead);
    logic [1:0] n;
    if (lead >= 8'hf0) n = 2'd3;
    else if (lead >= 8'he0) n = 2'd2;
    else n = 2'd1;
    return n;
  endfunction

  function automatic logic is_cjk(input logic [20:0] cp);
    return (cp >= 21'h003400 && cp <= 21'h004dbf) ||
           (cp >= 21'h004e00 && cp <= 21'h009fff) ||
           (cp >= 21'h00f900 && cp <= 21'h00faff);
  endfunction

  function automatic logic is_break(input logic [20:0] cp);
    return cp == 21'h000020 || cp == 21'h000009 || cp == 21'h00000a ||
           cp == 21'h00002d || cp == 21'h00002f || cp == 21'h003001 ||
           cp == 21'h003002;
  endfunction

endpackage

FILE: design/utf8_decode_wrap_detect_core.sv
// top level of the utf-8 decoder with wrap-opportunity detection
//
//  channel  ports                         payload
//  -------  ----------------------------  ----------------------------------------
//  bytes    in_push / in_full             in_item: data_byte, text_end
//  results  out_pop / out_empty           out_item: code_point, wrap_found,
//                                                   text_done, run_last
//
// the front takes one byte per cycle while the descriptor queue has room and
// decodes it in that cycle; each byte yields zero to four results
// the back issues one result per cycle from the queue head into the output
// register unless out_pop holds it there; a byte that yields no result is never queued
// in_full follows the queue fill; a pop stall on out_pop fills the queue
// synchronous active-low reset returns to no pending sequence, empty queue
module utf8_decode_wrap_detect_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  u8wd_pkg::in_item_t  in_item,
  output logic                out_empty,
  input  logic                out_pop,
  output u8wd_pkg::out_item_t out_item
);
  import u8wd_pkg::*;

  logic        in_acc;
  desc_t       f_desc, q_head;
  logic        f_push;
  logic        q_empty, q_full, q_pop;
  front_stat_t f_stat;

  // an item is taken whenever the queue can hold its descriptor
  assign in_acc  = in_push && !q_full;
  assign in_full = q_full;

  u8wd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .in_item   (in_item),
    .desc      (f_desc),
    .desc_push (f_push),
    .stat      (f_stat)
  );

  // decouples the byte side from the result side
  u8wd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (f_push),
    .wr_desc (f_desc),
    .pop     (q_pop),
    .head    (q_head),
    .empty   (q_empty),
    .full    (q_full)
  );

  // one result per cycle unless held by out_pop; head leaves with its last result
  u8wd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .head_valid (!q_empty),
    .head_pop   (q_pop),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .out_item   (out_item)
  );

  // end of text leaves the front idle with the wrap flag cleared
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_item.text_end |=> f_stat.idle && !f_stat.wrap)
    else $error("front state not cleared after end of text");

  // the final result of a text is also the last result of its byte
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_item.text_done |-> out_item.run_last)
    else $error("text_done without run_last");

  // results of one byte come out back to back
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_pop && !out_empty && !out_item.run_last |=> !out_empty)
    else $error("gap inside the results of one byte");

endmodule

FILE: design/u8wd_front.sv
// front: decode state, byte classes and wrap tracking, one byte per cycle on acc
module u8wd_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  acc,
  input  u8wd_pkg::in_item_t    in_item,
  output u8wd_pkg::desc_t       desc,
  output logic                  desc_push,
  output u8wd_pkg::front_stat_t stat
);
  import u8wd_pkg::*;

  logic [7:0]  lead_r, lead_nxt, mid_lead;
  logic [1:0]  cnt_r, cnt_nxt, mid_cnt;
  logic [17:0] bits_r, bits_nxt, mid_bits;
  logic [1:0]  tally_r, tally_nxt, mid_tally;
  logic        wrap_r, wrap_nxt, wrap_post;

  logic [7:0]  b;
  logic        pend, cont, ok, hit;
  logic [1:0]  need_cur;
  logic [20:0] cp_cat, x_cp;
  logic [2:0]  pre_n, post_n;
  logic        has_x;

  assign b        = in_item.data_byte;
  assign pend     = cnt_r != 2'd0;
  assign cont     = b[7:6] == 2'b10;
  assign need_cur = need_of(lead_r);
  assign cp_cat   = {bits_r[14:0], b[5:0]};

  always_comb begin
    case (need_cur)
      2'd1:    ok = cp_cat >= 21'h000080;
      2'd2:    ok = cp_cat >= 21'h000800 && !(cp_cat inside {[21'h00d800:21'h00dfff]});
      2'd3:    ok = cp_cat >= 21'h010000 && cp_cat <= 21'h10ffff;
      default: ok = 1'b0;
    endcase
  end

  always_comb begin
    mid_lead = lead_r;
    mid_cnt  = cnt_r;
    mid_bits = bits_r;
    pre_n    = 3'd0;
    has_x    = 1'b0;
    x_cp     = {13'd0, b};
    if (pend && cont) begin
      if (cnt_r != 2'd1) begin
        mid_bits = cp_cat[17:0];
        mid_cnt  = cnt_r - 2'd1;
      end else begin
        if (ok) begin
          has_x = 1'b1;
          x_cp  = cp_cat;
        end else begin
          pre_n = {1'b0, need_cur} + 3'd1;
        end
        mid_lead = 8'd0;
        mid_cnt  = 2'd0;
        mid_bits = 18'd0;
      end
    end else begin
      // interrupted sequence flushes first, then the byte starts over as a lead
      if (pend) pre_n = 3'd1 + {1'b0, need_cur} - {1'b0, cnt_r};
      mid_lead = 8'd0;
      mid_cnt  = 2'd0;
      mid_bits = 18'd0;
      if (b < 8'h80) begin
        has_x = 1'b1;
      end else if (b inside {[8'hc2:8'hdf]}) begin
        mid_lead = b;
        mid_cnt  = 2'd1;
        mid_bits = {13'd0, b[4:0]};
      end else if (b inside {[8'he0:8'hef]}) begin
        mid_lead = b;
        mid_cnt  = 2'd2;
        mid_bits = {14'd0, b[3:0]};
      end else if (b inside {[8'hf0:8'hf4]}) begin
        mid_lead = b;
        mid_cnt  = 2'd3;
        mid_bits = {15'd0, b[2:0]};
      end else begin
        has_x = 1'b1;
        x_cp  = REPL_CP;
      end
    end
  end

  // end of text flushes whatever is still buffered
  assign post_n = (in_item.text_end && mid_cnt != 2'd0) ?
                  3'd1 + {1'b0, need_of(mid_lead)} - {1'b0, mid_cnt} : 3'd0;

  assign hit       = has_x && is_cjk(x_cp);
  assign mid_tally = (hit && tally_r != 2'd2) ? tally_r + 2'd1 : tally_r;
  assign wrap_post = wrap_r | (has_x && is_break(x_cp)) | (hit && mid_tally == 2'd2);

  assign lead_nxt  = in_item.text_end ? 8'd0  : mid_lead;
  assign cnt_nxt   = in_item.text_end ? 2'd0  : mid_cnt;
  assign bits_nxt  = in_item.text_end ? 18'd0 : mid_bits;
  assign tally_nxt = in_item.text_end ? 2'd0  : mid_tally;
  assign wrap_nxt  = in_item.text_end ? 1'b0  : wrap_post;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r  <= 8'd0;
      cnt_r   <= 2'd0;
      bits_r  <= 18'd0;
      tally_r <= 2'd0;
      wrap_r  <= 1'b0;
    end else if (acc) begin
      lead_r  <= lead_nxt;
      cnt_r   <= cnt_nxt;
      bits_r  <= bits_nxt;
      tally_r <= tally_nxt;
      wrap_r  <= wrap_nxt;
    end
  end

  assign desc.tot_n     = pre_n + {2'd0, has_x} + post_n;
  assign desc.pre_n     = pre_n;
  assign desc.has_x     = has_x;
  assign desc.x_cp      = x_cp;
  assign desc.wrap_pre  = wrap_r;
  assign desc.wrap_post = wrap_post;
  assign desc.text_end  = in_item.text_end;
  assign desc_push      = acc && desc.tot_n != 3'd0;

  assign stat.idle = cnt_r == 2'd0 && tally_r == 2'd0;
  assign stat.wrap = wrap_r;

endmodule

FILE: design/u8wd_queue.sv
// small descriptor queue between front and back
module u8wd_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  u8wd_pkg::desc_t  wr_desc,
  input  logic             pop,
  output u8wd_pkg::desc_t  head,
  output logic             empty,
  output logic             full
);
  import u8wd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  desc_t         slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = cnt_r == CW'(DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  assign wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
  assign rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + CW'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_nxt;
      if (do_pop) rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= wr_desc;
  end

  assign head = slot_r[rd_ptr_r];

endmodule

FILE: design/u8wd_back.sv
// back: expands each descriptor into its results through an output register
module u8wd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  u8wd_pkg::desc_t     head,
  input  logic                head_valid,
  output logic                head_pop,
  input  logic                out_pop,
  output logic                out_empty,
  output u8wd_pkg::out_item_t out_item
);
  import u8wd_pkg::*;

  logic      [1:0] idx_r, idx_nxt;
  logic            valid_r;
  out_item_t       item_r, item_nxt;
  logic            load, last, at_x, after_x;
  logic      [2:0] k3;

  assign load    = head_valid && (!valid_r || out_pop);
  assign k3      = {1'b0, idx_r};
  assign at_x    = head.has_x && k3 == head.pre_n;
  assign after_x = head.has_x && k3 > head.pre_n;
  assign last    = k3 == head.tot_n - 3'd1;

  assign item_nxt.code_point = at_x ? head.x_cp : REPL_CP;
  assign item_nxt.wrap_found = (at_x || after_x) ? head.wrap_post : head.wrap_pre;
  assign item_nxt.text_done  = last && head.text_end;
  assign item_nxt.run_last   = last;

  assign idx_nxt  = last ? 2'd0 : idx_r + 2'd1;
  assign head_pop = load && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        idx_r   <= idx_nxt;
      end else if (out_pop) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) item_r <= item_nxt;
  end

  assign out_empty = !valid_r;
  assign out_item  = item_r;

endmodule

FILE: tb/utf8_decode_wrap_detect_core_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the utf-8 decoder with wrap-opportunity detection
module utf8_decode_wrap_detect_core_tb;
  import u8wd_pkg::*;

  localparam int CLK_HI      = 5;
  localparam int CLK_LO      = 5;
  localparam int RESET_LEN   = 10;
  localparam int GAP_MAX     = 6;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_MAX   = 20000;
  localparam int TAIL_CYCLES = 16;
  localparam int RANDOM_BYTES = 400;
  localparam int REPORT_MAX  = 10;

  // dut inputs, all known from time zero
  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      in_push = 1'b0;
  logic      in_full;
  in_item_t  in_item = '0;
  logic      out_empty;
  logic      out_pop = 1'b0;
  out_item_t out_item;

  // shared between sender and receiver
  int   idle_max = GAP_MAX;     // 0 gives a stretch with no idling
  logic hold_req = 1'b0;        // asks the receiver for one long hold-off

  // run statistics
  int n_bytes        = 0;
  int n_texts        = 0;
  int n_results      = 0;
  int n_errors       = 0;
  int n_stall_cycles = 0;

  // decoder state as predicted by the testbench
  logic [7:0]  dec_lead = '0;
  logic [1:0]  dec_left = '0;
  logic [17:0] dec_bits = '0;
  logic [1:0]  dec_cjk  = '0;
  logic        dec_wrap = 1'b0;

  // code points expected from the block, oldest first
  out_item_t   cp_expect_q[$];
  // code points produced by the byte being predicted
  logic [20:0] step_cp[$];
  logic        step_wrap[$];
  // bytes of the text being built by the random generator
  logic [7:0]  text_bytes[$];

  utf8_decode_wrap_detect_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

  always begin
    #CLK_LO clk = 1'b1;
    #CLK_HI clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  // continuation bytes that follow a given lead
  function automatic int conts_for(logic [7:0] lead);
    if (lead >= 8'hf0) return 3;
    if (lead >= 8'he0) return 2;
    return 1;
  endfunction

  // one decoded code point: update the sticky flag and the cjk tally first
  function automatic void note_cp(logic [20:0] cp);
    if (cp == 21'h000020 || cp == 21'h000009 || cp == 21'h00000a ||
        cp == 21'h00002d || cp == 21'h00002f || cp == 21'h003001 ||
        cp == 21'h003002)
      dec_wrap = 1'b1;
    if ((cp >= 21'h003400 && cp <= 21'h004dbf) ||
        (cp >= 21'h004e00 && cp <= 21'h009fff) ||
        (cp >= 21'h00f900 && cp <= 21'h00faff)) begin
      if (dec_cjk < 2'd2) dec_cjk = dec_cjk + 2'd1;
      // second ideograph of the text is a wrap point
      if (dec_cjk >= 2'd2) dec_wrap = 1'b1;
    end
    step_cp.push_back(cp);
    step_wrap.push_back(dec_wrap);
  endfunction

  // drop a sequence in progress: one replacement for the lead and each continuation
  function automatic void flush_seq();
    int total;
    if (dec_left == 2'd0) return;
    total = 1 + conts_for(dec_lead) - int'(dec_left);
    for (int k = 0; k < total; k++) note_cp(REPL_CP);
    dec_left = '0;
    dec_lead = '0;
    dec_bits = '0;
  endfunction

  function automatic void start_seq(logic [7:0] b);
    if (b < 8'h80) begin
      note_cp({13'd0, b});
    end else if (b >= 8'hc2 && b <= 8'hdf) begin
      dec_lead = b; dec_left = 2'd1; dec_bits = {13'd0, b[4:0]};
    end else if (b >= 8'he0 && b <= 8'hef) begin
      dec_lead = b; dec_left = 2'd2; dec_bits = {14'd0, b[3:0]};
    end else if (b >= 8'hf0 && b <= 8'hf4) begin
      dec_lead = b; dec_left = 2'd3; dec_bits = {15'd0, b[2:0]};
    end else begin
      // stray continuation, c0/c1 or f5..ff
      note_cp(REPL_CP);
    end
  endfunction

  // work out the code points one accepted item causes and queue them
  function automatic void predict_code_points(in_item_t it);
    logic [7:0]  b;
    logic [20:0] cp;
    logic        ok;
    int          need;
    int          n;
    out_item_t   e;
    b = it.data_byte;
    step_cp.delete();
    step_wrap.delete();
    if (dec_left == 2'd0) begin
      start_seq(b);
    end else if (b[7:6] != 2'b10) begin
      // interrupted sequence, the byte starts over as a lead
      flush_seq();
      start_seq(b);
    end else begin
      cp = {dec_bits[14:0], b[5:0]};
      if (dec_left > 2'd1) begin
        dec_bits = cp[17:0];
        dec_left = dec_left - 2'd1;
      end else begin
        need = conts_for(dec_lead);
        // reject overlong forms, surrogates and values past the last plane
        if (need == 1)      ok = cp >= 21'h000080;
        else if (need == 2) ok = cp >= 21'h000800 && (cp < 21'h00d800 || cp > 21'h00dfff);
        else                ok = cp >= 21'h010000 && cp <= 21'h10ffff;
        if (ok) note_cp(cp);
        else for (int k = 0; k <= need; k++) note_cp(REPL_CP);
        dec_left = '0;
        dec_lead = '0;
        dec_bits = '0;
      end
    end
    if (it.text_end) begin
      flush_seq();
      dec_cjk  = '0;
      dec_wrap = 1'b0;
    end
    n = step_cp.size();
    for (int k = 0; k < n; k++) begin
      e.code_point = step_cp[k];
      e.wrap_found = step_wrap[k];
      e.text_done  = it.text_end && (k == n - 1);
      e.run_last   = (k == n - 1);
      cp_expect_q.push_back(e);
    end
  endfunction

  // ---------------------------------------------------------------------
  // sender: one item per call, random gap first, then wait for acceptance
  // ---------------------------------------------------------------------
  task automatic push_byte(logic [7:0] b, logic last);
    int       gap;
    logic     took;
    in_item_t it;
    it.data_byte = b;
    it.text_end  = last;
    gap = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    // full is stable from the falling edge to the next rising edge
    do begin
      @(negedge clk);
      took = !in_full;
      if (in_full) n_stall_cycles++;
      @(posedge clk);
    end while (!took);
    n_bytes++;
    predict_code_points(it);
  endtask

  // ---------------------------------------------------------------------
  // receiver and checker
  // ---------------------------------------------------------------------
  task automatic report_error(string what, out_item_t want, out_item_t got);
    n_errors++;
    if (n_errors <= REPORT_MAX)
      $display("error @%0t: %s: expected %06h/%b/%b/%b, got %06h/%b/%b/%b",
               $realtime, what, want.code_point, want.wrap_found, want.text_done,
               want.run_last, got.code_point, got.wrap_found, got.text_done,
               got.run_last);
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    n_results++;
    if (cp_expect_q.size() == 0) begin
      report_error("result with nothing expected", '0, got);
    end else begin
      want = cp_expect_q.pop_front();
      if (got.code_point !== want.code_point || got.wrap_found !== want.wrap_found ||
          got.text_done !== want.text_done || got.run_last !== want.run_last)
        report_error("field mismatch", want, got);
    end
  endtask

  initial begin : receiver
    int        gap;
    logic      took;
    out_item_t got;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        // long hold-off so the descriptor queue fills and stalls the input
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      do begin
        @(negedge clk);
        took = !out_empty;
        got  = out_item;
        @(posedge clk);
      end while (!took);
      check_result(got);
    end
  end

  // ---------------------------------------------------------------------
  // random text generator
  // ---------------------------------------------------------------------
  function automatic int natural_len(logic [20:0] cp);
    if (cp < 21'h000080) return 1;
    if (cp < 21'h000800) return 2;
    if (cp < 21'h010000) return 3;
    return 4;
  endfunction

  // encode cp in n bytes; n above the natural length gives an overlong form
  function automatic void encode_into(logic [20:0] cp, int n);
    case (n)
      1: text_bytes.push_back({1'b0, cp[6:0]});
      2: begin
        text_bytes.push_back({3'b110, cp[10:6]});
        text_bytes.push_back({2'b10, cp[5:0]});
      end
      3: begin
        text_bytes.push_back({4'b1110, cp[15:12]});
        text_bytes.push_back({2'b10, cp[11:6]});
        text_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        text_bytes.push_back({5'b11110, cp[20:18]});
        text_bytes.push_back({2'b10, cp[17:12]});
        text_bytes.push_back({2'b10, cp[11:6]});
        text_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  // three quarters well-formed characters, the rest broken on purpose
  function automatic void add_char();
    int          kind;
    int          n;
    logic [20:0] cp;
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      encode_into(21'($urandom_range(0, 127)), 1);
    end else if (kind < 35) begin
      case ($urandom_range(0, 6))
        0: cp = 21'h000020;
        1: cp = 21'h000009;
        2: cp = 21'h00000a;
        3: cp = 21'h00002d;
        4: cp = 21'h00002f;
        5: cp = 21'h003001;
        default: cp = 21'h003002;
      endcase
      encode_into(cp, natural_len(cp));
    end else if (kind < 45) begin
      encode_into(21'($urandom_range(21'h80, 21'h7ff)), 2);
    end else if (kind < 55) begin
      encode_into(21'($urandom_range(21'h800, 21'hffff)), 3);
    end else if (kind < 67) begin
      // ideographs from each cjk block
      case ($urandom_range(0, 2))
        0: cp = 21'($urandom_range(21'h3400, 21'h4dbf));
        1: cp = 21'($urandom_range(21'h4e00, 21'h9fff));
        default: cp = 21'($urandom_range(21'hf900, 21'hfaff));
      endcase
      encode_into(cp, 3);
    end else if (kind < 75) begin
      encode_into(21'($urandom_range(21'h10000, 21'h10ffff)), 4);
    end else if (kind < 80) begin
      // truncated: the next lead or the end of text cuts it short
      cp = 21'($urandom_range(21'h80, 21'h10ffff));
      n  = natural_len(cp);
      encode_into(cp, n);
      repeat ($urandom_range(1, n - 1)) void'(text_bytes.pop_back());
    end else if (kind < 85) begin
      cp = 21'($urandom_range(0, 21'hffff));
      n  = natural_len(cp);
      encode_into(cp, (n == 4) ? 4 : int'($urandom_range(n + 1, 4)));
    end else if (kind < 89) begin
      encode_into(21'($urandom_range(21'hd800, 21'hdfff)), 3);
    end else if (kind < 93) begin
      encode_into(21'($urandom_range(21'h110000, 21'h1fffff)), 4);
    end else begin
      text_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic send_random_text();
    int n;
    text_bytes.delete();
    repeat ($urandom_range(1, 10)) add_char();
    n = text_bytes.size();
    for (int i = 0; i < n; i++) push_byte(text_bytes[i], i == n - 1);
    n_texts++;
  endtask

  // ---------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------

  // field extremes, a break character and an invalid lead
  task automatic test_single_bytes();
    push_byte(8'h00, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'h20, 1'b0);
    push_byte(8'hc0, 1'b0);
  endtask

  // two-byte form, then two ideographs in a text whose flag the earlier space already set
  task automatic test_multibyte();
    push_byte(8'hc3, 1'b0);
    push_byte(8'ha9, 1'b0);
    push_byte(8'he4, 1'b0);
    push_byte(8'hb8, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'he4, 1'b0);
    push_byte(8'hb8, 1'b0);
    push_byte(8'h81, 1'b0);
  endtask

  // overlong form, value past the last plane, interrupted sequence
  task automatic test_bad_sequences();
    push_byte(8'he0, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'hf4, 1'b0);
    push_byte(8'h90, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'he3, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h41, 1'b0);
  endtask

  // end of text in the middle of a four-byte form flushes three replacements
  task automatic test_text_end_flush();
    push_byte(8'hf0, 1'b0);
    push_byte(8'h9f, 1'b0);
    push_byte(8'h98, 1'b1);
    n_texts++;
  endtask

  // receiver holds off while the sender keeps offering back to back
  task automatic test_fill_stall();
    logic [7:0] ch;
    hold_req = 1'b1;
    idle_max = 0;
    for (int i = 0; i < 24; i++) begin
      ch = 8'h30 + i[7:0];
      push_byte(ch, i == 23);
    end
    n_texts++;
    idle_max = GAP_MAX;
  endtask

  task automatic test_random_texts();
    int goal;
    goal = n_bytes + RANDOM_BYTES;
    while (n_bytes < goal) begin
      // three texts in every ten run without idling on either side
      idle_max = ((n_texts % 10) < 3) ? 0 : GAP_MAX;
      send_random_text();
    end
    idle_max = GAP_MAX;
  endtask

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin : main_seq
    int waited;
    repeat (RESET_LEN) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_bytes();
    test_multibyte();
    test_bad_sequences();
    test_text_end_flush();
    test_fill_stall();
    test_random_texts();

    in_push <= 1'b0;
    // drain: wait for every expected code point, bounded
    waited = 0;
    while (cp_expect_q.size() != 0 && waited < DRAIN_MAX) begin
      @(posedge clk);
      waited++;
    end
    if (cp_expect_q.size() != 0) begin
      $display("error: %0d expected code points never arrived", cp_expect_q.size());
      n_errors += cp_expect_q.size();
    end
    // let any late extra result show up
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d bytes in %0d texts, %0d code points checked, %0d errors",
             n_bytes, n_texts, n_results, n_errors);
    $display("input held off by a full queue for %0d cycles", n_stall_cycles);
    if (n_errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // watchdog against a hung handshake
  initial begin : watchdog
    #2_000_000;
    $display("timeout: handshake hung");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
